[rtl/keyword_lexer_core_assert.svh]
// assertion macros used by the checker file
`ifndef KEYWORD_LEXER_CORE_ASSERT_SVH
`define KEYWORD_LEXER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define KLX_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyword_lexer_core check failed");

// next-cycle implication, disabled while in reset
`define KLX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyword_lexer_core check failed");

`endif

[rtl/klx_pkg.sv]
`timescale 1ns / 1ps

package klx_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_IDENT  = 2'd2,
        MODE_DOT    = 2'd3
    } scan_mode_t;

    localparam logic [4:0] KIND_INT        = 5'd0;
    localparam logic [4:0] KIND_IDENT      = 5'd1;
    localparam logic [4:0] KIND_KW_BASE    = 5'd2;
    localparam logic [4:0] KIND_PUNCT_BASE = 5'd16;
    localparam logic [4:0] KIND_DOTDOT     = 5'd24;
    localparam logic [4:0] KIND_EOF        = 5'd25;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam int KW_COUNT    = 14;
    localparam int KW_TEXT_LEN = 6;

    // keyword text, first byte in the lowest bits, zero padded
    localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_7372_6176,   // vars
        48'h0000_0074_6573,   // set
        48'h6f72_6f73_6f79,   // yosoro
        48'h0000_0075_6869,   // ihu
        48'h0000_0072_6f68,   // hor
        48'h0065_6c69_6877,   // while
        48'h0000_0074_6e69,   // int
        48'h0079_6172_7261,   // array
        48'h0000_0000_746c,   // lt
        48'h0000_0000_7467,   // gt
        48'h0000_0000_656c,   // le
        48'h0000_0000_6567,   // ge
        48'h0000_0000_7165,   // eq
        48'h0000_0071_656e    // neq
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd4, 3'd3, 3'd6, 3'd3, 3'd3, 3'd5, 3'd3, 3'd5, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3
    };

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        last;
        logic [15:0] length;
        logic [15:0] start;
        logic [4:0]  kind;
    } token_t;

    // up to two tokens from one source byte, in order a then b
    typedef struct packed {
        logic   a_valid;
        token_t a;
        logic   b_valid;
        token_t b;
    } push_t;

    typedef struct packed {
        logic   valid;
        token_t token;
    } q_head_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
    endfunction

    // {hit, index} for the eight single-byte tokens
    function automatic logic [3:0] punct_index(input logic [7:0] b);
        logic [3:0] r;
        case (b)
            8'h2b:   r = 4'b1000;   // +
            8'h2d:   r = 4'b1001;   // -
            8'h2c:   r = 4'b1010;   // ,
            8'h3a:   r = 4'b1011;   // :
            8'h7b:   r = 4'b1100;   // {
            8'h7d:   r = 4'b1101;   // }
            8'h5b:   r = 4'b1110;   // [
            8'h5d:   r = 4'b1111;   // ]
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

    // keywords are distinct, so at most one entry hits
    function automatic logic [4:0] keyword_kind(input logic [8*KW_TEXT_LEN-1:0] prefix,
                                                input logic [15:0] len);
        logic [4:0] kind;
        logic       hit;
        kind = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            hit = (len == 16'(KW_LEN[i]));
            for (int j = 0; j < KW_TEXT_LEN; j++) begin
                if ((j < int'(KW_LEN[i])) && (prefix[8*j +: 8] != KW_TEXT[i][8*j +: 8])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = KIND_KW_BASE + 5'(i);
            end
        end
        return kind;
    endfunction

endpackage

[rtl/klx_front.sv]
`timescale 1ns / 1ps

module klx_front #(
    parameter int POSITION_BITS   = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      char_byte,
    input  logic            end_of_source,
    output klx_pkg::push_t  push
);

    localparam int IDX_BITS = $clog2(KEYWORD_MAX_LEN);

    klx_pkg::scan_mode_t     mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [15:0]             len_reg, len_next;
    logic [7:0]              prefix_reg [KEYWORD_MAX_LEN];

    logic                    prefix_we;
    logic [IDX_BITS-1:0]     prefix_idx;
    logic [8*klx_pkg::KW_TEXT_LEN-1:0] prefix_vec;

    logic       c_digit, c_word, c_cont, c_dot, c_space;
    logic [3:0] c_punct;
    logic       extend, dotdot, open_run;
    logic [15:0] pos16, start16, len_inc;
    logic [4:0]  run_kind;
    klx_pkg::scan_mode_t idle_mode;

    assign c_digit = klx_pkg::is_digit(char_byte);
    assign c_word  = klx_pkg::is_alpha(char_byte) || (char_byte == 8'h5f);
    assign c_cont  = c_word || c_digit;
    assign c_dot   = (char_byte == 8'h2e);
    assign c_space = klx_pkg::is_space(char_byte);
    assign c_punct = klx_pkg::punct_index(char_byte);

    assign extend   = ((mode_reg == klx_pkg::MODE_NUMBER) && c_digit) ||
                      ((mode_reg == klx_pkg::MODE_IDENT) && c_cont);
    assign dotdot   = (mode_reg == klx_pkg::MODE_DOT) && c_dot;
    assign open_run = (mode_reg == klx_pkg::MODE_NUMBER) || (mode_reg == klx_pkg::MODE_IDENT);
    assign len_inc  = (len_reg == klx_pkg::LEN_MAX) ? len_reg : len_reg + 16'd1;

    generate
        if (POSITION_BITS >= 16) begin : g_wide_pos
            assign pos16   = pos_reg[15:0];
            assign start16 = start_reg[15:0];
        end else begin : g_narrow_pos
            assign pos16   = {{(16-POSITION_BITS){1'b0}}, pos_reg};
            assign start16 = {{(16-POSITION_BITS){1'b0}}, start_reg};
        end
    endgenerate

    always_comb
    begin
        for (int j = 0; j < klx_pkg::KW_TEXT_LEN; j++) begin
            prefix_vec[8*j +: 8] = prefix_reg[j];
        end
    end

    assign run_kind = (mode_reg == klx_pkg::MODE_NUMBER) ? klx_pkg::KIND_INT :
                      klx_pkg::keyword_kind(prefix_vec, len_reg);

    // mode a byte starts when taken fresh
    assign idle_mode = c_space ? klx_pkg::MODE_IDLE :
                       c_digit ? klx_pkg::MODE_NUMBER :
                       c_word  ? klx_pkg::MODE_IDENT :
                       c_dot   ? klx_pkg::MODE_DOT : klx_pkg::MODE_IDLE;

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        if (accept) begin
            if (end_of_source) begin
                mode_next = klx_pkg::MODE_IDLE;
            end else begin
                case (mode_reg)
                    klx_pkg::MODE_NUMBER: mode_next = c_digit ? klx_pkg::MODE_NUMBER : idle_mode;
                    klx_pkg::MODE_IDENT:  mode_next = c_cont ? klx_pkg::MODE_IDENT : idle_mode;
                    klx_pkg::MODE_DOT:    mode_next = c_dot ? klx_pkg::MODE_IDLE : idle_mode;
                    default:              mode_next = idle_mode;
                endcase
            end
        end
    end

    // tokens and run bookkeeping
    always_comb
    begin
        push       = '0;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        prefix_we  = 1'b0;
        prefix_idx = '0;
        if (accept) begin
            if (end_of_source) begin
                push.a_valid  = open_run;
                push.a.kind   = run_kind;
                push.a.start  = start16;
                push.a.length = len_reg;
                push.b_valid  = 1'b1;
                push.b.kind   = klx_pkg::KIND_EOF;
                push.b.start  = pos16;
                push.b.length = 16'd0;
                push.b.last   = 1'b1;
                pos_next      = '0;
                start_next    = '0;
                len_next      = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (extend) begin
                    len_next = len_inc;
                    if ((mode_reg == klx_pkg::MODE_IDENT) &&
                        (len_reg < 16'(KEYWORD_MAX_LEN))) begin
                        prefix_we  = 1'b1;
                        prefix_idx = len_reg[IDX_BITS-1:0];
                    end
                end else if (dotdot) begin
                    push.a_valid  = 1'b1;
                    push.a.kind   = klx_pkg::KIND_DOTDOT;
                    push.a.start  = start16;
                    push.a.length = 16'd2;
                end else begin
                    push.a_valid  = open_run;
                    push.a.kind   = run_kind;
                    push.a.start  = start16;
                    push.a.length = len_reg;
                    if (!c_space && (c_digit || c_word || c_dot)) begin
                        start_next = pos_reg;
                        len_next   = 16'd1;
                    end
                    if (c_word) begin
                        prefix_we  = 1'b1;
                        prefix_idx = '0;
                    end
                    push.b_valid  = c_punct[3];
                    push.b.kind   = klx_pkg::KIND_PUNCT_BASE + {2'b00, c_punct[2:0]};
                    push.b.start  = pos16;
                    push.b.length = 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= klx_pkg::MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prefix_we) begin
            prefix_reg[prefix_idx] <= char_byte;
        end
    end

endmodule

[rtl/klx_queue.sv]
`timescale 1ns / 1ps

module klx_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  klx_pkg::push_t   push,
    output logic             room,
    output klx_pkg::q_head_t head,
    input  logic             pop
);

    klx_pkg::token_t mem_reg [klx_pkg::QUEUE_DEPTH];
    logic [klx_pkg::PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [klx_pkg::PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [klx_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [klx_pkg::COUNT_BITS-1:0] n_write;
    klx_pkg::token_t first_tok;
    logic            do_pop;

    // space for two tokens keeps a byte from ever being refused mid-way
    assign room = (count_reg <= klx_pkg::COUNT_BITS'(klx_pkg::QUEUE_DEPTH - 2));

    assign n_write   = klx_pkg::COUNT_BITS'(push.a_valid) + klx_pkg::COUNT_BITS'(push.b_valid);
    assign first_tok = push.a_valid ? push.a : push.b;
    assign do_pop    = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.token = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_write[klx_pkg::PTR_BITS-1:0];
        rd_ptr_next = rd_ptr_reg + klx_pkg::PTR_BITS'(do_pop);
        count_next  = count_reg + n_write - klx_pkg::COUNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_write != '0) begin
            mem_reg[wr_ptr_reg] <= first_tok;
        end
        if (push.a_valid && push.b_valid) begin
            mem_reg[wr_ptr_reg + 1'b1] <= push.b;
        end
    end

endmodule

[rtl/klx_back.sv]
`timescale 1ns / 1ps

module klx_back (
    input  logic             clk,
    input  logic             rst_n,
    input  klx_pkg::q_head_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output klx_pkg::token_t  out_token
);

    logic            valid_reg, valid_next;
    klx_pkg::token_t tok_reg;

    assign pop        = head.valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_token  = tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            tok_reg <= head.token;
        end
    end

endmodule

[rtl/keyword_lexer_core.sv]
// keyword_lexer_core: byte-stream tokenizer
//
// input channel s_axis: one source byte per transfer in tdata; a transfer
// with tlast high is the end marker and its byte is ignored
// output channel m_axis: one token per transfer, tdata carries kind, start
// offset and length; tlast marks the eof token that closes a source
//
// a byte is taken every cycle while the token queue has room for two
// tokens; one byte gives at most two tokens, the output drains one per
// cycle while m_axis_tready is high, so the sustained rate is one byte per
// cycle unless tokens arrive faster than one per cycle on average (the single
// output register sets it); a token passes the queue, then that register
//
// reset clears the scan state, the offset counter and the queue; no clearing
// pass is needed and the first byte can be taken right after reset
// when the receiver stalls the output register holds its token, the queue
// fills, and s_axis_tready drops once fewer than two entries are free
// after eof the offsets restart at zero for the next source
`timescale 1ns / 1ps

module keyword_lexer_core #(
    parameter int POSITION_BITS   = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] char_byte
    input  logic        s_axis_tlast,    // end_of_source
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [4:0] token_kind, [20:5] token_start,
                                         // [36:21] token_length, [39:37] zero
    output logic        m_axis_tlast     // is_last
);

    // front to queue: the tokens produced by the byte taken this cycle
    klx_pkg::push_t   push;
    klx_pkg::q_head_t head;
    klx_pkg::token_t  out_token;
    logic             room;
    logic             pop;
    logic             accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    // scanner: classifies each byte and closes runs
    klx_front #(
        .POSITION_BITS   (POSITION_BITS),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .char_byte     (s_axis_tdata),
        .end_of_source (s_axis_tlast),
        .push          (push)
    );

    // short token queue decouples the scanner from the output side
    klx_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .head  (head),
        .pop   (pop)
    );

    // output register facing the receiver
    klx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_token (out_token)
    );

    assign m_axis_tdata = {3'b000, out_token.length, out_token.start, out_token.kind};
    assign m_axis_tlast = out_token.last;

endmodule

[rtl/keyword_lexer_core_checker.sv]
`timescale 1ns / 1ps
`include "keyword_lexer_core_assert.svh"

module keyword_lexer_core_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic in_seen;

    // at least one input transfer since reset; no token can exist before that
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_seen <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_seen <= 1'b1;
        end
    end

    // a stalled token holds
    `KLX_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // eof token is the only one with tlast, and it has zero length
    `KLX_ASSERT_SAME(a_eof_shape, m_axis_tvalid,
        (m_axis_tlast == (m_axis_tdata[4:0] == klx_pkg::KIND_EOF)) &&
        (!m_axis_tlast || (m_axis_tdata[36:21] == 16'd0)))

    // other tokens are never empty, kinds stay in range, padding is zero
    `KLX_ASSERT_SAME(a_tok_shape, m_axis_tvalid && !m_axis_tlast,
        (m_axis_tdata[36:21] != 16'd0) && (m_axis_tdata[4:0] < klx_pkg::KIND_EOF) &&
        (m_axis_tdata[39:37] == 3'b000))

    // no token appears without an input transfer before it
    `KLX_ASSERT_SAME(a_no_spurious, m_axis_tvalid, in_seen)

endmodule

bind keyword_lexer_core keyword_lexer_core_checker u_checker (.*);

[tb/sv/keyword_lexer_core_tb.sv]
`timescale 1ns / 1ps

// tracks the lexer state and holds the tokens still owed by the block
class token_tracker;

    string                keywords [14];
    string                punct_chars;
    klx_pkg::token_t      pending_tokens [$];
    int                   errors;

    klx_pkg::scan_mode_t  mode;
    logic [15:0]          offset;
    logic [15:0]          run_start;
    logic [15:0]          run_len;
    logic [7:0]           prefix [6];

    function new();
        keywords = '{"vars", "set", "yosoro", "ihu", "hor", "while", "int",
                     "array", "lt", "gt", "le", "ge", "eq", "neq"};
        punct_chars = "+-,:{}[]";
        errors = 0;
        clear_scan();
        offset = '0;
    endfunction

    function string keyword_text(int idx);
        return keywords[idx];
    endfunction

    function void clear_scan();
        mode = klx_pkg::MODE_IDLE;
        run_start = '0;
        run_len = '0;
        foreach (prefix[i]) prefix[i] = 8'h00;
    endfunction

    function bit is_blank(logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
    endfunction

    function bit is_num(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function void push_token(logic [4:0] kind, logic [15:0] start, logic [15:0] len,
                             logic last);
        klx_pkg::token_t t;
        t.kind = kind;
        t.start = start;
        t.length = len;
        t.last = last;
        pending_tokens.push_back(t);
    endfunction

    // whole-word match only, a longer word never hits
    function logic [4:0] word_kind();
        bit hit;
        for (int i = 0; i < 14; i++) begin
            if (keywords[i].len() == int'(run_len)) begin
                hit = 1'b1;
                for (int j = 0; j < keywords[i].len(); j++) begin
                    if (prefix[j] != keywords[i][j]) hit = 1'b0;
                end
                if (hit) return klx_pkg::KIND_KW_BASE + 5'(i);
            end
        end
        return klx_pkg::KIND_IDENT;
    endfunction

    function void close_run();
        if (mode == klx_pkg::MODE_NUMBER)
            push_token(klx_pkg::KIND_INT, run_start, run_len, 1'b0);
        else if (mode == klx_pkg::MODE_IDENT)
            push_token(word_kind(), run_start, run_len, 1'b0);
        mode = klx_pkg::MODE_IDLE;
    endfunction

    function void grow_run(logic [7:0] b);
        if (mode == klx_pkg::MODE_IDENT && run_len < 16'd6) prefix[run_len] = b;
        if (run_len != klx_pkg::LEN_MAX) run_len = run_len + 16'd1;
    endfunction

    // byte seen with no run open
    function void open_from_idle(logic [7:0] b);
        mode = klx_pkg::MODE_IDLE;
        if (is_blank(b)) return;
        if (is_num(b) || is_letter(b) || b == "_" || b == ".") begin
            run_start = offset;
            run_len = 16'd1;
            if (is_num(b)) mode = klx_pkg::MODE_NUMBER;
            else if (b == ".") mode = klx_pkg::MODE_DOT;
            else begin
                mode = klx_pkg::MODE_IDENT;
                prefix[0] = b;
            end
            return;
        end
        for (int i = 0; i < punct_chars.len(); i++) begin
            if (punct_chars[i] == b)
                push_token(klx_pkg::KIND_PUNCT_BASE + 5'(i), offset, 16'd1, 1'b0);
        end
    endfunction

    // called for every accepted input transfer
    function void take_byte(logic [7:0] b, logic eos);
        if (eos) begin
            close_run();
            push_token(klx_pkg::KIND_EOF, offset, 16'd0, 1'b1);
            clear_scan();
            offset = '0;
            return;
        end
        case (mode)
            klx_pkg::MODE_NUMBER:
                if (is_num(b)) grow_run(b);
                else begin
                    close_run();
                    open_from_idle(b);
                end
            klx_pkg::MODE_IDENT:
                if (is_letter(b) || is_num(b) || b == "_") grow_run(b);
                else begin
                    close_run();
                    open_from_idle(b);
                end
            klx_pkg::MODE_DOT:
                if (b == ".") begin
                    push_token(klx_pkg::KIND_DOTDOT, run_start, 16'd2, 1'b0);
                    mode = klx_pkg::MODE_IDLE;
                end
                else open_from_idle(b);
            default:
                open_from_idle(b);
        endcase
        offset = offset + 16'd1;
    endfunction

    // called for every accepted output transfer
    function void check_token(logic [39:0] data, logic last);
        klx_pkg::token_t want;
        if (pending_tokens.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("token with none expected: kind %0d start %0d len %0d last %0d",
                         data[4:0], data[20:5], data[36:21], last);
            return;
        end
        want = pending_tokens.pop_front();
        if (data[4:0] !== want.kind || data[20:5] !== want.start ||
            data[36:21] !== want.length || data[39:37] !== 3'b000 || last !== want.last) begin
            errors++;
            if (errors <= 10)
                $display("token mismatch: exp kind %0d start %0d len %0d last %0d, got kind %0d start %0d len %0d last %0d pad %b",
                         want.kind, want.start, want.length, want.last,
                         data[4:0], data[20:5], data[36:21], last, data[39:37]);
        end
    endfunction

endclass

module keyword_lexer_core_tb;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    token_tracker tracker;

    // idle odds in percent, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    // request for one long receiver hold-off, and its completion
    bit hold_req;
    bit hold_done;
    int bytes_offered;

    keyword_lexer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // watchdog, far above the slowest legal run under the heaviest idling
    initial
    begin
        #10_000_000;
        $display("** keyword_lexer_core: FAILED **");
        $finish;
    end

    // both monitors at the rising edge; inputs noted before outputs checked
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) tracker.take_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) tracker.check_token(m_axis_tdata, m_axis_tlast);
        end
    end

    // receiver: random stalls, or one long hold-off counted here
    initial
    begin
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                for (int i = 0; i < 300; i++)
                begin
                    m_axis_tready <= 1'b0;
                    @(negedge clk);
                end
                hold_done = 1'b1;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one byte; starts and returns at a falling edge
    task automatic offer_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do @(posedge clk); while (!s_axis_tready);
        bytes_offered++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) offer_byte(s[i], 1'b0);
    endtask

    // end marker carries a random byte that must be ignored
    task automatic send_end();
        offer_byte(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return "_";
    endfunction

    // one source: mostly well-formed tokens, some noise, then the end marker
    task automatic send_random_source();
        int    n_tok;
        int    pick;
        int    len;
        string kw;
        n_tok = $urandom_range(12, 1);
        for (int t = 0; t < n_tok; t++)
        begin
            pick = $urandom_range(99);
            if (pick < 25) send_text(tracker.keyword_text($urandom_range(13)));
            else if (pick < 35) begin
                // near misses of keywords: extended, cut short, upper case
                kw = tracker.keyword_text($urandom_range(13));
                case ($urandom_range(2))
                    0: begin
                        send_text(kw);
                        offer_byte(word_char(), 1'b0);
                    end
                    1: send_text(kw.substr(0, kw.len() - 2));
                    default: send_text(kw.toupper());
                endcase
            end
            else if (pick < 50) begin
                len = $urandom_range(10, 1);
                offer_byte(($urandom_range(4) == 0) ? 8'("_") : 8'("a" + $urandom_range(25)),
                           1'b0);
                for (int i = 1; i < len; i++) offer_byte(word_char(), 1'b0);
            end
            else if (pick < 60) begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++) offer_byte(8'("0" + $urandom_range(9)), 1'b0);
            end
            else if (pick < 75) offer_byte(tracker.punct_chars[$urandom_range(7)], 1'b0);
            else if (pick < 80) send_text("..");
            else if (pick < 83) send_text(".");
            else if (pick < 85) send_text("...");
            else if (pick < 95) begin
                pick = $urandom_range(6);
                offer_byte((pick == 6) ? 8'h20 : 8'(9 + pick), 1'b0);
            end
            else offer_byte(8'($urandom_range(255)), 1'b0);
            // a separator about half the time, else runs merge
            if ($urandom_range(1)) offer_byte(8'h20, 1'b0);
        end
        send_end();
    endtask

    task automatic random_phase(input int n_bytes);
        int stop_at;
        stop_at = bytes_offered + n_bytes;
        while (bytes_offered < stop_at) send_random_source();
    endtask

    initial
    begin
        tracker = new();
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'h00;
        s_axis_tlast <= 1'b0;
        hold_req = 1'b0;
        bytes_offered = 0;
        send_idle_pct = 33;
        recv_idle_pct = 79;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: eof on an empty source, word opened by an underscore, word with digits,
        // lone dot, three dots, high byte with no run open, word one past a keyword,
        // dot dropped at the end marker
        offer_byte(8'hff, 1'b1);
        send_text("_9a 42.x...:");
        offer_byte(8'h80, 1'b0);
        send_text("yosorox");
        offer_byte(8'h0a, 1'b0);
        send_text(".");
        offer_byte(8'h5a, 1'b1);

        random_phase(550);

        send_idle_pct = 79;
        recv_idle_pct = 33;
        random_phase(550);

        // no idling; the receiver holds off while bytes keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        random_phase(550);

        // keyword closed by punctuation, range token just before the end marker
        send_text(" while-..");
        send_end();

        s_axis_tvalid <= 1'b0;
        while (tracker.pending_tokens.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending_tokens.size() == 0)
            $display("** keyword_lexer_core: PASSED **");
        else
            $display("** keyword_lexer_core: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/klx_pkg.sv
rtl/klx_front.sv
rtl/klx_queue.sv
rtl/klx_back.sv
rtl/keyword_lexer_core.sv
rtl/keyword_lexer_core_checker.sv
tb/sv/keyword_lexer_core_tb.sv
